### sv/dnt_pkg.sv
// Package for the directory name table.
// Holds opcode, status and sequencer state types and the fixed field widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dnt_pkg;

  localparam int OPCODE_W = 2;
  localparam int HEAD_W   = 64;
  localparam int TAIL_W   = 8;
  localparam int SECTOR_W = 16;
  localparam int STATUS_W = 2;
  localparam int INDEX_W  = 6;
  localparam int HEAD_BYTES = HEAD_W / 8;

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } state_e;

endpackage

`default_nettype wire

### sv/dnt_req_if.sv
// Request channel of the directory name table: valid/ready plus request payload.
// Depends on dnt_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface dnt_req_if;
  logic                           valid;
  logic                           ready;
  logic [dnt_pkg::OPCODE_W-1:0]   opcode;
  logic [dnt_pkg::HEAD_W-1:0]     name_head;
  logic [dnt_pkg::TAIL_W-1:0]     name_tail;
  logic [dnt_pkg::SECTOR_W-1:0]   new_sector;
  logic                           add_as_dir;

  modport source (output valid, opcode, name_head, name_tail, new_sector, add_as_dir,
                  input ready);
  modport sink   (input valid, opcode, name_head, name_tail, new_sector, add_as_dir,
                  output ready);
endinterface

`default_nettype wire

### sv/dnt_rsp_if.sv
// Response channel of the directory name table: valid/ready plus result payload.
// Depends on dnt_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface dnt_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [dnt_pkg::STATUS_W-1:0]   status;
  logic [dnt_pkg::INDEX_W-1:0]    entry_index;
  logic [dnt_pkg::SECTOR_W-1:0]   found_sector;
  logic                           found_dir;

  modport source (output valid, status, entry_index, found_sector, found_dir,
                  input ready);
  modport sink   (input valid, status, entry_index, found_sector, found_dir,
                  output ready);
endinterface

`default_nettype wire

### sv/dnt_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dnt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### sv/directory_name_table.sv
// Directory name table: lookup, add and remove of named entries.
// Each transaction scans all ENTRIES entries through one RAM read port, one per cycle.
// From accept to result valid the sequencer steps through scan, drain and commit.
// The request is taken in idle only, so a new transaction waits until the last one commits.
// Reset (async, active low) clears all valid marks, emptying the table at once.
// Depends on dnt_pkg, dnt_req_if, dnt_rsp_if and dnt_ram.
`timescale 1ns / 1ps
`default_nettype none

module directory_name_table #(
  parameter int ENTRIES    = 64,
  parameter int NAME_BYTES = 9
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  dnt_req_if.sink   req_i,
  dnt_rsp_if.source rsp_o
);

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int NAME_W = NAME_BYTES * 8;
  localparam int SEC_W  = dnt_pkg::SECTOR_W;
  localparam int WORD_W = NAME_W + SEC_W + 1;

  dnt_pkg::state_e state_q, state_d;

  logic [IDX_W-1:0]  cnt_q;
  logic              rd_vld_q;
  logic [IDX_W-1:0]  rd_idx_q;
  logic [ENTRIES-1:0] valid_q;

  logic              hit_q;
  logic [IDX_W-1:0]  hit_idx_q;
  logic [SEC_W-1:0]  hit_sector_q;
  logic              hit_dir_q;
  logic              free_q;
  logic [IDX_W-1:0]  free_idx_q;

  logic [dnt_pkg::OPCODE_W-1:0] op_q;
  logic [NAME_W-1:0] name_q;
  logic [SEC_W-1:0]  sector_q;
  logic              dir_q;

  logic                          out_vld_q;
  logic [dnt_pkg::STATUS_W-1:0]  out_status_q;
  logic [dnt_pkg::INDEX_W-1:0]   out_index_q;
  logic [SEC_W-1:0]              out_sector_q;
  logic                          out_dir_q;

  logic              in_fire;
  logic              rd_en;
  logic              commit_fire;
  logic              scan_last;
  logic [NAME_W-1:0] req_name;
  logic [WORD_W-1:0] ram_rdata;
  logic              cmp_hit;
  logic              add_ok;
  logic              rm_ok;

  dnt_pkg::status_e  res_status;
  logic [IDX_W-1:0]  res_idx;
  logic [SEC_W-1:0]  res_sector;
  logic              res_dir;

  // Name normalization: bytes after the first zero byte read as zero.
  always_comb begin
    logic [7:0] b;
    logic       ended;
    ended    = 1'b0;
    req_name = '0;
    for (int i = 0; i < NAME_BYTES; i++) begin
      b = 8'h00;
      if (i < dnt_pkg::HEAD_BYTES) begin
        b = req_i.name_head[8*i +: 8];
      end else if (i == dnt_pkg::HEAD_BYTES) begin
        b = req_i.name_tail;
      end
      if (b == 8'h00) begin
        ended = 1'b1;
      end
      req_name[8*i +: 8] = ended ? 8'h00 : b;
    end
  end

  dnt_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (commit_fire && add_ok),
    .waddr_i (free_idx_q),
    .wdata_i ({dir_q, sector_q, name_q}),
    .raddr_i (cnt_q),
    .rdata_o (ram_rdata)
  );

  assign scan_last = (cnt_q == IDX_W'(ENTRIES - 1));
  assign cmp_hit   = rd_vld_q && valid_q[rd_idx_q] && (ram_rdata[NAME_W-1:0] == name_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dnt_pkg::S_IDLE:   if (req_i.valid) state_d = dnt_pkg::S_SCAN;
      dnt_pkg::S_SCAN:   if (scan_last) state_d = dnt_pkg::S_DRAIN;
      dnt_pkg::S_DRAIN:  state_d = dnt_pkg::S_COMMIT;
      dnt_pkg::S_COMMIT: if (!out_vld_q || rsp_o.ready) state_d = dnt_pkg::S_IDLE;
      default:           state_d = dnt_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    req_i.ready = 1'b0;
    rd_en       = 1'b0;
    commit_fire = 1'b0;
    unique case (state_q)
      dnt_pkg::S_IDLE:   req_i.ready = 1'b1;
      dnt_pkg::S_SCAN:   rd_en = 1'b1;
      dnt_pkg::S_DRAIN:  ;
      dnt_pkg::S_COMMIT: commit_fire = !out_vld_q || rsp_o.ready;
      default:           ;
    endcase
  end

  assign in_fire = req_i.valid && req_i.ready;

  // Result selection
  always_comb begin
    res_status = dnt_pkg::ST_NOT_FOUND;
    res_idx    = '0;
    res_sector = '0;
    res_dir    = 1'b0;
    add_ok     = 1'b0;
    rm_ok      = 1'b0;
    unique case (dnt_pkg::op_e'(op_q))
      dnt_pkg::OP_LOOKUP: begin
        if (hit_q) begin
          res_status = dnt_pkg::ST_OK;
          res_idx    = hit_idx_q;
          res_sector = hit_sector_q;
          res_dir    = hit_dir_q;
        end
      end
      dnt_pkg::OP_ADD: begin
        if (hit_q) begin
          res_status = dnt_pkg::ST_DUPLICATE;
        end else if (!free_q) begin
          res_status = dnt_pkg::ST_FULL;
        end else begin
          add_ok     = 1'b1;
          res_status = dnt_pkg::ST_OK;
          res_idx    = free_idx_q;
          res_sector = sector_q;
          res_dir    = dir_q;
        end
      end
      dnt_pkg::OP_REMOVE: begin
        if (hit_q) begin
          rm_ok      = 1'b1;
          res_status = dnt_pkg::ST_OK;
          res_idx    = hit_idx_q;
          res_sector = hit_sector_q;
          res_dir    = hit_dir_q;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= dnt_pkg::S_IDLE;
      cnt_q     <= '0;
      rd_vld_q  <= 1'b0;
      valid_q   <= '0;
      hit_q     <= 1'b0;
      free_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_en;
      if (in_fire) begin
        cnt_q  <= '0;
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else if (rd_en && !scan_last) begin
        cnt_q <= cnt_q + IDX_W'(1);
      end
      if (cmp_hit) begin
        hit_q <= 1'b1;
      end
      if (rd_vld_q && !valid_q[rd_idx_q]) begin
        free_q <= 1'b1;
      end
      if (commit_fire && add_ok) begin
        valid_q[free_idx_q] <= 1'b1;
      end
      if (commit_fire && rm_ok) begin
        valid_q[hit_idx_q] <= 1'b0;
      end
      if (commit_fire) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rd_idx_q <= cnt_q;
    if (in_fire) begin
      op_q     <= req_i.opcode;
      name_q   <= req_name;
      sector_q <= req_i.new_sector;
      dir_q    <= req_i.add_as_dir;
    end
    // first hit and first free entry win
    if (cmp_hit && !hit_q) begin
      hit_idx_q    <= rd_idx_q;
      hit_sector_q <= ram_rdata[NAME_W +: SEC_W];
      hit_dir_q    <= ram_rdata[WORD_W-1];
    end
    if (rd_vld_q && !valid_q[rd_idx_q] && !free_q) begin
      free_idx_q <= rd_idx_q;
    end
    if (commit_fire) begin
      out_status_q <= res_status;
      out_index_q  <= dnt_pkg::INDEX_W'(res_idx);
      out_sector_q <= res_sector;
      out_dir_q    <= res_dir;
    end
  end

  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.entry_index  = out_index_q;
  assign rsp_o.found_sector = out_sector_q;
  assign rsp_o.found_dir    = out_dir_q;

`ifndef SYNTHESIS
  a_add_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit_fire && add_ok) |=> valid_q[free_idx_q])
    else $error("add did not set entry valid");

  a_rm_clears_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit_fire && rm_ok) |=> !valid_q[hit_idx_q])
    else $error("remove did not clear entry valid");

  a_hit_is_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dnt_pkg::S_COMMIT && hit_q) |-> valid_q[hit_idx_q])
    else $error("hit on an invalid entry");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status != dnt_pkg::ST_OK) |->
      (rsp_o.entry_index == '0 && rsp_o.found_sector == '0 && !rsp_o.found_dir))
    else $error("failed transaction carries nonzero fields");
`endif

endmodule

`default_nettype wire
